@@ rtl/sbsd_pkg.sv @@
// Shared types for the signed binary-search divider.
// Holds the controller state encoding and the controller-to-datapath command bundle.
// No dependencies.
package sbsd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } sbsd_state_t;

  typedef struct packed {
    logic load;    // capture operand magnitudes and signs
    logic step;    // run one quotient-bit iteration
    logic finish;  // apply sign and flags, write the output register
  } sbsd_cmd_t;

endpackage

@@ rtl/sbsd_dp.sv @@
// Datapath of the signed divider: operand magnitudes, shift-subtract iteration,
// sign/flag fix-up and the output register. Depends on sbsd_pkg.
module sbsd_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  sbsd_pkg::sbsd_cmd_t          cmd,
  input  logic signed [DATA_WIDTH-1:0] in_dividend,
  input  logic signed [DATA_WIDTH-1:0] in_divisor,
  output logic signed [DATA_WIDTH-1:0] out_quotient,
  output logic                         out_overflow,
  output logic                         out_divide_by_zero
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0] quo_r, quo_nxt;    // dividend bits shift out, quotient bits shift in
  logic [W-1:0] rem_r, rem_nxt;    // partial remainder, below the divisor when the divisor is nonzero
  logic [W-1:0] div_r;
  logic         neg_r;
  logic         dz_r;

  logic [W:0]   rem_shift;
  logic [W+1:0] diff;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;

  logic [W-1:0] q_r, q_nxt;
  logic         ovf_r, ovf_nxt;
  logic         dzo_r;

  always_comb begin
    mag_a = in_dividend[W-1] ? (~in_dividend + 1'b1) : in_dividend;
    mag_b = in_divisor[W-1] ? (~in_divisor + 1'b1) : in_divisor;

    rem_shift = {rem_r, quo_r[W-1]};
    diff      = {1'b0, rem_shift} - {2'b00, div_r};

    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.step) begin
      if (!diff[W+1]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
    end

    // Sign, zero-divisor and saturation fix-up on the finished magnitude
    ovf_nxt = 1'b0;
    if (dz_r || quo_r == '0) begin
      q_nxt = '0;
    end else if (neg_r) begin
      q_nxt = ~quo_r + 1'b1;
    end else if (quo_r[W-1]) begin
      q_nxt   = {1'b0, {(W-1){1'b1}}};
      ovf_nxt = 1'b1;
    end else begin
      q_nxt = quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r <= mag_a;
      rem_r <= '0;
      div_r <= mag_b;
      neg_r <= in_dividend[W-1] ^ in_divisor[W-1];
      dz_r  <= (in_divisor == '0);
    end else begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.finish) begin
      q_r   <= q_nxt;
      ovf_r <= ovf_nxt;
      dzo_r <= dz_r;
    end
  end

  assign out_quotient       = q_r;
  assign out_overflow       = ovf_r;
  assign out_divide_by_zero = dzo_r;

endmodule

@@ rtl/sbsd_ctrl.sv @@
// Controller of the signed divider: state machine, iteration counter and
// output valid flag. Depends on sbsd_pkg.
module sbsd_ctrl #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output sbsd_pkg::sbsd_cmd_t cmd
);

  localparam int CW = $clog2(DATA_WIDTH);
  localparam logic [CW-1:0] LAST_CNT = CW'(DATA_WIDTH - 1);

  sbsd_pkg::sbsd_state_t state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbsd_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state_r)
      sbsd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = LAST_CNT;
          state_nxt = sbsd_pkg::ST_CALC;
        end
      end
      sbsd_pkg::ST_CALC: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = sbsd_pkg::ST_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      sbsd_pkg::ST_FIN: begin
        // wait until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = sbsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sbsd_pkg::ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  a_load_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == sbsd_pkg::ST_CALC && cnt_r == LAST_CNT))
    else $error("load did not start iteration");

  a_calc_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbsd_pkg::ST_CALC && cnt_r == '0) |=> state_r == sbsd_pkg::ST_FIN)
    else $error("iteration did not end after last step");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");

endmodule

@@ rtl/signed_binary_search_divider_unit.sv @@
// Signed divider, quotient truncated toward zero, one quotient bit per cycle.
// Operands load at the input transfer, then DATA_WIDTH shift-subtract steps in ST_CALC and one
// sign fix-up step in ST_FIN, which writes the output register and raises out_valid.
// A new transfer is taken only in idle, after the previous item's fix-up; a stalled result
// holds the fix-up step until the output register drains.
// Reset (rst_n, synchronous, active low) returns the controller to idle and drops out_valid.
module signed_binary_search_divider_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_dividend,
  input  logic signed [DATA_WIDTH-1:0] in_divisor,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_quotient,
  output logic                         out_overflow,
  output logic                         out_divide_by_zero
);

  // Command bundle from the controller. The controller only takes a new
  // transfer when idle; the result waits in the datapath output register,
  // so a new item can be loaded and iterated while the previous result is
  // still stalled downstream. The fix-up cycle holds until that register frees.
  sbsd_pkg::sbsd_cmd_t cmd;

  sbsd_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: magnitudes are exact at DATA_WIDTH bits unsigned (the most
  // negative value included), so the only overflow is the positive-quotient
  // case of the most negative value over minus one, which saturates.
  // A zero divisor yields quotient zero with the divide_by_zero flag.
  sbsd_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .in_dividend        (in_dividend),
    .in_divisor         (in_divisor),
    .out_quotient       (out_quotient),
    .out_overflow       (out_overflow),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

@@ bench/quotient_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the signed divider: predicts every quotient and compares it with the block.
// Watches both valid/stall channels of signed_binary_search_divider_unit; needs nothing else.
module quotient_checker #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [WIDTH-1:0] in_dividend,
  input  logic signed [WIDTH-1:0] in_divisor,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [WIDTH-1:0] out_quotient,
  input  logic                    out_overflow,
  input  logic                    out_divide_by_zero,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic signed [WIDTH-1:0] quotient;
    logic                    overflow;
    logic                    divide_by_zero;
  } quotient_result_t;

  quotient_result_t awaited_quotients[$];

  // Work on magnitudes one bit wider so the most negative operand is exact.
  function automatic quotient_result_t predict_quotient(input logic [WIDTH-1:0] num,
                                                        input logic [WIDTH-1:0] den);
    logic             num_neg;
    logic             den_neg;
    logic [WIDTH:0]   num_mag;
    logic [WIDTH:0]   den_mag;
    logic [WIDTH:0]   mag_q;
    logic [WIDTH:0]   neg_q;
    quotient_result_t r;
    num_neg = num[WIDTH-1];
    den_neg = den[WIDTH-1];
    num_mag = num_neg ? ({1'b0, ~num} + 1'b1) : {1'b0, num};
    den_mag = den_neg ? ({1'b0, ~den} + 1'b1) : {1'b0, den};
    r = '0;
    if (den_mag == '0) begin
      r.divide_by_zero = 1'b1;
    end else begin
      mag_q = num_mag / den_mag;
      if (mag_q == '0) begin
        r.quotient = '0;
      end else if (num_neg != den_neg) begin
        neg_q = ~mag_q + 1'b1;
        r.quotient = neg_q[WIDTH-1:0];
      end else if (mag_q > {2'b00, {(WIDTH-1){1'b1}}}) begin
        r.quotient = {1'b0, {(WIDTH-1){1'b1}}};
        r.overflow = 1'b1;
      end else begin
        r.quotient = mag_q[WIDTH-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    quotient_result_t exp_r;
    if (!rst_n) begin
      // Drop anything left over and start the counts from zero.
      awaited_quotients.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_quotients.push_back(predict_quotient(in_dividend, in_divisor));
      end
      if (out_valid && !out_stall) begin
        if (awaited_quotients.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result q=%0d ovf=%b dz=%b", $realtime,
                     out_quotient, out_overflow, out_divide_by_zero);
          fail_count = fail_count + 1;
        end else begin
          exp_r = awaited_quotients.pop_front();
          if (out_quotient !== exp_r.quotient || out_overflow !== exp_r.overflow ||
              out_divide_by_zero !== exp_r.divide_by_zero) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp q=%0d ovf=%b dz=%b got q=%0d ovf=%b dz=%b",
                       $realtime, exp_r.quotient, exp_r.overflow, exp_r.divide_by_zero,
                       out_quotient, out_overflow, out_divide_by_zero);
            fail_count = fail_count + 1;
          end
        end
      end
      pending = awaited_quotients.size();
    end
  end

endmodule

@@ bench/signed_binary_search_divider_unit_test.sv @@
`timescale 1ns / 100ps
// Top of the divider testbench: clock, reset, operand stimulus, result stall and verdict.
// Depends on signed_binary_search_divider_unit and quotient_checker.
module signed_binary_search_divider_unit_test;

  localparam int WIDTH = 32;
  // Allow far more than one item's latency plus the longest gap and stall run.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * (WIDTH + 2);
  localparam int RANDOM_ITEMS = 900;
  localparam logic signed [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic signed [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [WIDTH-1:0] in_dividend = '0;
  logic signed [WIDTH-1:0] in_divisor = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [WIDTH-1:0] out_quotient;
  logic                    out_overflow;
  logic                    out_divide_by_zero;

  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  // Set while both sides must run without any idling.
  logic quiet_phase = 1'b0;

  always #10 clk = ~clk;

  signed_binary_search_divider_unit #(
    .DATA_WIDTH(WIDTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_dividend       (in_dividend),
    .in_divisor        (in_divisor),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_quotient      (out_quotient),
    .out_overflow      (out_overflow),
    .out_divide_by_zero(out_divide_by_zero)
  );

  quotient_checker #(
    .WIDTH(WIDTH)
  ) checker_inst (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_dividend       (in_dividend),
    .in_divisor        (in_divisor),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_quotient      (out_quotient),
    .out_overflow      (out_overflow),
    .out_divide_by_zero(out_divide_by_zero),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // Stall the result side at random, with a probability of 8 percent, except in the quiet phase.
  always @(posedge clk) begin
    out_stall <= !quiet_phase && ($urandom_range(99, 0) < 8);
  end

  // Watchdog: end the run once nothing has transferred for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Magnitude of random width, then a random sign: spreads over small and large values.
  function automatic logic signed [WIDTH-1:0] scaled_random();
    logic signed [WIDTH-1:0] v;
    v = $urandom >> $urandom_range(WIDTH-1, 0);
    if ($urandom_range(1, 0))
      v = -v;
    return v;
  endfunction

  function automatic logic signed [WIDTH-1:0] pick_extreme();
    case ($urandom_range(5, 0))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return '0;
      3: return 1;
      4: return '1;
      default: return MOST_NEG + 1;
    endcase
  endfunction

  // Present one operand pair, hold it until the transfer, then maybe drop valid for a gap.
  // Entered right after a rising edge; every drive below lands on an edge.
  task automatic send_operands(input logic signed [WIDTH-1:0] a,
                               input logic signed [WIDTH-1:0] b);
    in_valid    <= 1'b1;
    in_dividend <= a;
    in_divisor  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Gaps of varied length land on every phase of the iteration.
    if (!quiet_phase && $urandom_range(99, 0) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk);
    end
  endtask

  initial begin
    int                      kind;
    logic signed [WIDTH-1:0] a;
    logic signed [WIDTH-1:0] b;

    // Hold reset low, then release it.
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, zero divisor, saturation, every sign combination.
    send_operands(0, 1);
    send_operands(0, -1);
    send_operands(0, 0);
    send_operands(5, 0);
    send_operands(MOST_NEG, 0);
    send_operands(-1, 0);
    send_operands(MOST_NEG, -1);
    send_operands(MOST_NEG, 1);
    send_operands(MOST_NEG, 2);
    send_operands(MOST_NEG, MOST_NEG);
    send_operands(MOST_NEG, MOST_POS);
    send_operands(MOST_POS, MOST_NEG);
    send_operands(MOST_POS, -1);
    send_operands(MOST_POS, 1);
    send_operands(MOST_POS, MOST_POS);
    send_operands(7, 2);
    send_operands(-7, 2);
    send_operands(7, -2);
    send_operands(-7, -2);
    send_operands(1, MOST_NEG);
    send_operands(-1, MOST_NEG);
    send_operands(3, 7);
    send_operands(-1, -1);
    send_operands(1, 1);

    // Random part: mostly plain division with random content, a share of corner cases.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_phase <= (i >= 400 && i < 600);
      kind = $urandom_range(99, 0);
      if (kind < 40) begin
        a = $urandom;
        b = $urandom;
      end else if (kind < 55) begin
        a = $urandom;
        b = $signed($urandom_range(32, 0)) - 16;
      end else if (kind < 70) begin
        // Exact multiple, remainder zero, unless the product overflows WIDTH bits.
        b = scaled_random();
        a = b * scaled_random();
      end else if (kind < 80) begin
        a = scaled_random();
        b = scaled_random();
      end else if (kind < 90) begin
        a = $urandom_range(1, 0) ? pick_extreme() : scaled_random();
        b = pick_extreme();
      end else if (kind < 95) begin
        a = $urandom;
        b = '0;
      end else begin
        // Divisor larger than the dividend: quotient truncates to zero.
        a = $signed($urandom_range(64, 0)) - 32;
        b = $urandom | {2'b01, {(WIDTH-2){1'b0}}};
        b[WIDTH-1] = 1'b0;
      end
      send_operands(a, b);
    end
    quiet_phase <= 1'b0;
    in_valid <= 1'b0;

    // Drain: wait for every result, then a little longer for stray ones.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
